// ----- design/page_framebuffer_refresh_controller_unit_macros.svh -----
// ----------------------------------------------------------------------------
// page_framebuffer_refresh_controller_unit_macros
// Assertion macros shared by the checker; expect clk and rst_n in scope.
// ----------------------------------------------------------------------------
`ifndef PAGE_FRAMEBUFFER_REFRESH_CONTROLLER_UNIT_MACROS_SVH
`define PAGE_FRAMEBUFFER_REFRESH_CONTROLLER_UNIT_MACROS_SVH

// same-cycle implication
`define PFRC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pfrc: same-cycle property violated");

// next-cycle implication
`define PFRC_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pfrc: next-cycle property violated");

`endif

// ----- design/pfrc_pkg.sv -----
// ----------------------------------------------------------------------------
// pfrc_pkg
// Types and constants of the page framebuffer refresh controller.
// ----------------------------------------------------------------------------
package pfrc_pkg;

  typedef enum logic [2:0] {
    OP_PROCESS = 3'd0,
    OP_PIXEL   = 3'd1,
    OP_FILL    = 3'd2,
    OP_COLUMN  = 3'd3,
    OP_MARK    = 3'd4,
    OP_CLEAR   = 3'd5
  } opcode_t;

  typedef enum logic [1:0] {
    KIND_NONE = 2'd0,
    KIND_CMD  = 2'd1,
    KIND_DATA = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_CMD  = 2'd1,
    PH_DATA = 2'd2
  } phase_t;

  typedef enum logic [1:0] {
    ST_CLEAR = 2'd0,
    ST_IDLE  = 2'd1,
    ST_EDIT  = 2'd2,
    ST_DATA  = 2'd3
  } state_t;

  localparam int unsigned PAGE_W = 3;

  // display address command bytes
  localparam logic [7:0] CMD_ADDR_MODE  = 8'h20;
  localparam logic [7:0] ADDR_MODE_HORZ = 8'h00;
  localparam logic [7:0] CMD_COL_RANGE  = 8'h21;
  localparam logic [7:0] COL_FIRST      = 8'h00;
  localparam logic [7:0] CMD_PAGE_RANGE = 8'h22;

endpackage

// ----- design/page_framebuffer_refresh_controller_unit.sv -----
// ----------------------------------------------------------------------------
// page_framebuffer_refresh_controller_unit
// Page-organized monochrome frame store with dirty-page refresh sequencer.
// ----------------------------------------------------------------------------
// The frame store is one synchronous memory of PAGES*ceil(COLUMNS/8) words of
// eight column bytes. After reset, and after a clear-all item, busy stays high
// for one memory sweep while the store is zeroed, word by word. Pixel and
// column writes read the word, then write it back modified; a fill reads and
// rewrites each word it touches in turn; a data process streams the page's
// ceil(COLUMNS/8) memory words, one memory word per cycle. Results are
// registered, shown one per cycle with out_valid high, and cannot be held off.
module page_framebuffer_refresh_controller_unit #(
  parameter int unsigned COLUMNS = 128,
  parameter int unsigned PAGES   = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  in_opcode,
  input  logic [7:0]  in_column_x,
  input  logic [7:0]  in_row_y,
  input  logic [3:0]  in_page_index,
  input  logic [3:0]  in_page_last,
  input  logic [7:0]  in_fill_width,
  input  logic [7:0]  in_byte_value,
  input  logic        in_pixel_on,
  input  logic        in_link_ready,
  input  logic        in_link_busy,
  input  logic        in_link_accepts,
  output logic        out_valid,
  output logic [1:0]  out_transfer_kind,
  output logic [63:0] out_payload,
  output logic        out_last_word
);
  import pfrc_pkg::*;

  localparam int unsigned WPP   = (COLUMNS + 7) / 8;
  localparam int unsigned DEPTH = PAGES * WPP;
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned WW    = (WPP > 1) ? $clog2(WPP) : 1;

  function automatic logic [AW-1:0] word_addr(input logic [PAGE_W-1:0] pg,
                                              input logic [WW-1:0] wd);
    int unsigned a;
    a = int'(pg) * WPP + int'(wd);
    return AW'(a);
  endfunction

  state_t               state_r, state_nxt;
  phase_t               phase_r, phase_nxt;
  logic [PAGES-1:0]     pending_r, pending_nxt;
  logic [PAGE_W-1:0]    cur_page_r, cur_page_nxt;
  logic [AW-1:0]        clr_addr_r, clr_addr_nxt;
  logic [PAGE_W-1:0]    ed_page_r, ed_page_nxt;
  logic [WW-1:0]        ed_word_r, ed_word_nxt;
  logic [8:0]           ed_lo_r, ed_lo_nxt;
  logic [8:0]           ed_hi_r, ed_hi_nxt;
  logic [7:0]           ed_keep_r, ed_keep_nxt;
  logic [7:0]           ed_set_r, ed_set_nxt;
  logic [WW-1:0]        dcnt_r, dcnt_nxt;
  logic                 out_valid_r, out_valid_nxt;
  kind_t                out_kind_r, out_kind_nxt;
  logic [63:0]          out_payload_r, out_payload_nxt;
  logic                 out_last_r, out_last_nxt;

  logic [63:0]          mem [DEPTH];
  logic [63:0]          rdata_r;
  logic                 mem_we;
  logic [AW-1:0]        mem_waddr;
  logic [AW-1:0]        mem_raddr;
  logic [63:0]          mem_wdata;

  logic                 acc;
  logic                 pg_ok, x_ok, y_ok;
  logic [8:0]           x9, fill_end, word_col, next_col, col;
  logic [7:0]           pix_mask;
  logic [PAGE_W-1:0]    low_page;
  logic                 found;
  logic [PAGES-1:0]     mark_mask;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata_r <= mem[mem_raddr];
  end

  assign acc      = start && (state_r == ST_IDLE);
  assign x9       = {1'b0, in_column_x};
  assign pg_ok    = {1'b0, in_page_index} < 5'(PAGES);
  assign x_ok     = x9 < 9'(COLUMNS);
  assign y_ok     = {1'b0, in_row_y} < 9'(PAGES * 8);
  assign fill_end = x9 + {1'b0, in_fill_width};
  assign pix_mask = 8'b1 << in_row_y[2:0];
  assign word_col = 9'({ed_word_r, 3'b000});
  assign next_col = word_col + 9'd8;

  always_comb begin
    low_page = '0;
    found    = 1'b0;
    for (int p = 0; p < PAGES; p++) begin
      if (pending_r[p] && !found) begin
        low_page = PAGE_W'(p);
        found    = 1'b1;
      end
    end
  end

  always_comb begin
    for (int p = 0; p < PAGES; p++) begin
      mark_mask[p] = (4'(p) >= in_page_index) && (4'(p) <= in_page_last);
    end
  end

  always_comb begin
    state_nxt       = state_r;
    phase_nxt       = phase_r;
    pending_nxt     = pending_r;
    cur_page_nxt    = cur_page_r;
    clr_addr_nxt    = clr_addr_r;
    ed_page_nxt     = ed_page_r;
    ed_word_nxt     = ed_word_r;
    ed_lo_nxt       = ed_lo_r;
    ed_hi_nxt       = ed_hi_r;
    ed_keep_nxt     = ed_keep_r;
    ed_set_nxt      = ed_set_r;
    dcnt_nxt        = dcnt_r;
    out_valid_nxt   = 1'b0;
    out_kind_nxt    = out_kind_r;
    out_payload_nxt = out_payload_r;
    out_last_nxt    = out_last_r;
    mem_we          = 1'b0;
    mem_waddr       = '0;
    mem_wdata       = '0;
    mem_raddr       = '0;
    col             = '0;

    unique case (state_r)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_addr_r;
        if (clr_addr_r == AW'(DEPTH - 1)) begin
          state_nxt = ST_IDLE;
        end else begin
          clr_addr_nxt = clr_addr_r + 1'b1;
        end
      end

      ST_IDLE: begin
        if (acc) begin
          unique case (opcode_t'(in_opcode))
            OP_PROCESS: begin
              if (!in_link_ready) begin
                phase_nxt = PH_IDLE;
              end else if (in_link_busy) begin
                phase_nxt = phase_r;
              end else if (phase_r == PH_CMD) begin
                if (in_link_accepts) begin
                  phase_nxt = PH_DATA;
                  mem_raddr = word_addr(cur_page_r, '0);
                  dcnt_nxt  = '0;
                  state_nxt = ST_DATA;
                end
              end else begin
                phase_nxt = PH_IDLE;
                if (found) begin
                  cur_page_nxt = low_page;
                  if (in_link_accepts) begin
                    pending_nxt[low_page] = 1'b0;
                    phase_nxt       = PH_CMD;
                    out_valid_nxt   = 1'b1;
                    out_kind_nxt    = KIND_CMD;
                    out_last_nxt    = 1'b1;
                    out_payload_nxt = {5'b0, low_page, 5'b0, low_page, CMD_PAGE_RANGE,
                                       8'(COLUMNS - 1), COL_FIRST, CMD_COL_RANGE,
                                       ADDR_MODE_HORZ, CMD_ADDR_MODE};
                  end
                end
              end
            end
            OP_PIXEL: begin
              if (x_ok && y_ok) begin
                ed_page_nxt = PAGE_W'(in_row_y[5:3]);
                ed_word_nxt = WW'(in_column_x >> 3);
                ed_lo_nxt   = x9;
                ed_hi_nxt   = x9 + 9'd1;
                ed_keep_nxt = ~pix_mask;
                ed_set_nxt  = in_pixel_on ? pix_mask : 8'h00;
                mem_raddr   = word_addr(PAGE_W'(in_row_y[5:3]), WW'(in_column_x >> 3));
                state_nxt   = ST_EDIT;
              end
            end
            OP_FILL: begin
              if (pg_ok && x_ok && (in_fill_width != 8'd0)) begin
                ed_page_nxt = in_page_index[PAGE_W-1:0];
                ed_word_nxt = WW'(in_column_x >> 3);
                ed_lo_nxt   = x9;
                ed_hi_nxt   = (fill_end > 9'(COLUMNS)) ? 9'(COLUMNS) : fill_end;
                ed_keep_nxt = 8'h00;
                ed_set_nxt  = in_byte_value;
                mem_raddr   = word_addr(in_page_index[PAGE_W-1:0], WW'(in_column_x >> 3));
                state_nxt   = ST_EDIT;
              end
            end
            OP_COLUMN: begin
              if (pg_ok && x_ok) begin
                ed_page_nxt = in_page_index[PAGE_W-1:0];
                ed_word_nxt = WW'(in_column_x >> 3);
                ed_lo_nxt   = x9;
                ed_hi_nxt   = x9 + 9'd1;
                ed_keep_nxt = 8'h00;
                ed_set_nxt  = in_byte_value;
                mem_raddr   = word_addr(in_page_index[PAGE_W-1:0], WW'(in_column_x >> 3));
                state_nxt   = ST_EDIT;
              end
            end
            OP_MARK: begin
              if ((in_page_index <= in_page_last) && ({1'b0, in_page_last} < 5'(PAGES))) begin
                pending_nxt = pending_r | mark_mask;
              end
            end
            OP_CLEAR: begin
              clr_addr_nxt = '0;
              state_nxt    = ST_CLEAR;
            end
            default: begin
              state_nxt = ST_IDLE;
            end
          endcase
        end
      end

      ST_EDIT: begin
        mem_we    = 1'b1;
        mem_waddr = word_addr(ed_page_r, ed_word_r);
        mem_wdata = rdata_r;
        for (int b = 0; b < 8; b++) begin
          col = word_col + 9'(b);
          if ((col >= ed_lo_r) && (col < ed_hi_r)) begin
            mem_wdata[8*b +: 8] = (rdata_r[8*b +: 8] & ed_keep_r) | ed_set_r;
          end
        end
        if (next_col < ed_hi_r) begin
          ed_word_nxt = ed_word_r + 1'b1;
          mem_raddr   = word_addr(ed_page_r, ed_word_r + 1'b1);
        end else begin
          state_nxt = ST_IDLE;
        end
      end

      ST_DATA: begin
        out_valid_nxt   = 1'b1;
        out_kind_nxt    = KIND_DATA;
        out_payload_nxt = rdata_r;
        out_last_nxt    = (dcnt_r == WW'(WPP - 1));
        if (dcnt_r == WW'(WPP - 1)) begin
          state_nxt = ST_IDLE;
        end else begin
          dcnt_nxt  = dcnt_r + 1'b1;
          mem_raddr = word_addr(cur_page_r, dcnt_r + 1'b1);
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      phase_r     <= PH_IDLE;
      pending_r   <= '1;
      cur_page_r  <= '0;
      clr_addr_r  <= '0;
      dcnt_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      pending_r   <= pending_nxt;
      cur_page_r  <= cur_page_nxt;
      clr_addr_r  <= clr_addr_nxt;
      dcnt_r      <= dcnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ed_page_r     <= ed_page_nxt;
    ed_word_r     <= ed_word_nxt;
    ed_lo_r       <= ed_lo_nxt;
    ed_hi_r       <= ed_hi_nxt;
    ed_keep_r     <= ed_keep_nxt;
    ed_set_r      <= ed_set_nxt;
    out_kind_r    <= out_kind_nxt;
    out_payload_r <= out_payload_nxt;
    out_last_r    <= out_last_nxt;
  end

  assign busy              = (state_r != ST_IDLE);
  assign out_valid         = out_valid_r;
  assign out_transfer_kind = out_kind_r;
  assign out_payload       = out_payload_r;
  assign out_last_word     = out_last_r;

endmodule

// ----- design/pfrc_checker.sv -----
// ----------------------------------------------------------------------------
// pfrc_checker
// Port-level checks of the refresh controller, bound to the top level.
// ----------------------------------------------------------------------------
`include "page_framebuffer_refresh_controller_unit_macros.svh"

module pfrc_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       start,
  input logic       busy,
  input logic [2:0] in_opcode,
  input logic       out_valid,
  input logic [1:0] out_transfer_kind,
  input logic       out_last_word
);
  import pfrc_pkg::*;

  // a shown result always carries a real transfer
  `PFRC_ASSERT_IMP(a_kind_sent, out_valid, out_transfer_kind == KIND_CMD || out_transfer_kind == KIND_DATA)
  // the address command is a single-result item
  `PFRC_ASSERT_IMP(a_cmd_last, out_valid && out_transfer_kind == KIND_CMD, out_last_word)
  // page data words come back to back until the last one
  `PFRC_ASSERT_NXT(a_data_burst, out_valid && !out_last_word, out_valid && out_transfer_kind == KIND_DATA)
  // edits never produce a result
  `PFRC_ASSERT_NXT(a_edit_quiet, start && !busy && in_opcode != OP_PROCESS, !out_valid)

endmodule

bind page_framebuffer_refresh_controller_unit pfrc_checker u_pfrc_checker (.*);

// ----- sim/page_framebuffer_refresh_controller_unit_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// page_framebuffer_refresh_controller_unit_tb
// Self-checking bench for the page framebuffer refresh controller. Items are
// applied through the start/busy handshake and mirrored into a behavioral
// copy of the frame store, the pending-page bitmap and the link sequencer.
// Every strobed transfer is checked in order against that copy: directed
// corner cases first, then random refresh rounds mixed with noise, then a
// back-to-back burst.
// ----------------------------------------------------------------------------
module page_framebuffer_refresh_controller_unit_tb;
  import pfrc_pkg::*;

  localparam int unsigned COLUMNS      = 128;
  localparam int unsigned PAGES        = 8;
  localparam int unsigned WORDS        = (COLUMNS + 7) / 8;
  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned DRAIN_CYCLES = 200;
  localparam int unsigned RANDOM_ITEMS = 290;
  localparam int unsigned BURST_ITEMS  = 40;
  localparam logic [2:0]  OP_SPARE_6   = 3'd6;
  localparam logic [2:0]  OP_SPARE_7   = 3'd7;

  typedef struct {
    logic [2:0] op;
    logic [7:0] x;
    logic [7:0] y;
    logic [3:0] pg;
    logic [3:0] pl;
    logic [7:0] width;
    logic [7:0] val;
    logic       on;
    logic       rdy;
    logic       lbusy;
    logic       acc;
  } cmd_item_t;

  typedef struct {
    kind_t       kind;
    logic [63:0] payload;
    logic        last;
  } transfer_t;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [2:0]  in_opcode;
  logic [7:0]  in_column_x;
  logic [7:0]  in_row_y;
  logic [3:0]  in_page_index;
  logic [3:0]  in_page_last;
  logic [7:0]  in_fill_width;
  logic [7:0]  in_byte_value;
  logic        in_pixel_on;
  logic        in_link_ready;
  logic        in_link_busy;
  logic        in_link_accepts;
  logic        out_valid;
  logic [1:0]  out_transfer_kind;
  logic [63:0] out_payload;
  logic        out_last_word;

  // mirror of the block state
  logic [7:0]  frame_mirror [COLUMNS*PAGES];
  logic [7:0]  dirty_pages;
  logic [2:0]  refresh_page;
  phase_t      link_phase;

  transfer_t   transfer_q [$];
  int unsigned mismatches;
  int unsigned items_sent;
  int unsigned cycles;
  bit          gaps_on;

  page_framebuffer_refresh_controller_unit dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_opcode        (in_opcode),
    .in_column_x      (in_column_x),
    .in_row_y         (in_row_y),
    .in_page_index    (in_page_index),
    .in_page_last     (in_page_last),
    .in_fill_width    (in_fill_width),
    .in_byte_value    (in_byte_value),
    .in_pixel_on      (in_pixel_on),
    .in_link_ready    (in_link_ready),
    .in_link_busy     (in_link_busy),
    .in_link_accepts  (in_link_accepts),
    .out_valid        (out_valid),
    .out_transfer_kind(out_transfer_kind),
    .out_payload      (out_payload),
    .out_last_word    (out_last_word)
  );

  initial clk = 1'b0;
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("page_framebuffer_refresh_controller_unit_tb: done, errors");
      $finish;
    end
  end

  // updates the mirror for one item and queues the transfers it causes
  function automatic void refresh_step(input cmd_item_t it);
    int unsigned n;
    logic [63:0] word;
    transfer_t t;
    case (it.op)
      OP_PROCESS: begin
        if (!it.rdy) begin
          link_phase = PH_IDLE;
        end else if (!it.lbusy) begin
          if (link_phase == PH_CMD) begin
            if (it.acc) begin
              link_phase = PH_DATA;
              for (int w = 0; w < WORDS; w++) begin
                word = '0;
                for (int b = 0; b < 8; b++)
                  if (w * 8 + b < COLUMNS)
                    word[8*b +: 8] = frame_mirror[refresh_page * COLUMNS + w * 8 + b];
                t.kind    = KIND_DATA;
                t.payload = word;
                t.last    = (w == WORDS - 1);
                transfer_q.push_back(t);
              end
            end
          end else begin
            link_phase = PH_IDLE;
            if (dirty_pages != '0) begin
              for (int p = PAGES - 1; p >= 0; p--)
                if (dirty_pages[p]) refresh_page = 3'(p);
              // a refused command leaves the page pending
              if (it.acc) begin
                dirty_pages[refresh_page] = 1'b0;
                link_phase = PH_CMD;
                t.kind    = KIND_CMD;
                t.payload = {5'd0, refresh_page, 5'd0, refresh_page, CMD_PAGE_RANGE,
                             8'(COLUMNS - 1), COL_FIRST, CMD_COL_RANGE,
                             ADDR_MODE_HORZ, CMD_ADDR_MODE};
                t.last    = 1'b1;
                transfer_q.push_back(t);
              end
            end
          end
        end
      end
      OP_PIXEL: begin
        if (it.x < COLUMNS && it.y < PAGES * 8)
          frame_mirror[(it.y >> 3) * COLUMNS + it.x][it.y[2:0]] = it.on;
      end
      OP_FILL: begin
        if (it.pg < PAGES && it.x < COLUMNS) begin
          n = it.width;
          if (it.x + n > COLUMNS) n = COLUMNS - it.x;
          for (int i = 0; i < n; i++) frame_mirror[it.pg * COLUMNS + it.x + i] = it.val;
        end
      end
      OP_COLUMN: begin
        if (it.pg < PAGES && it.x < COLUMNS) frame_mirror[it.pg * COLUMNS + it.x] = it.val;
      end
      OP_MARK: begin
        if (it.pg <= it.pl && it.pl < PAGES)
          for (int p = it.pg; p <= it.pl; p++) dirty_pages[p] = 1'b1;
      end
      OP_CLEAR: begin
        foreach (frame_mirror[i]) frame_mirror[i] = '0;
      end
      default: ;
    endcase
  endfunction

  function automatic cmd_item_t rand_item();
    cmd_item_t it;
    it.op    = 3'($urandom_range(0, 7));
    it.x     = 8'($urandom_range(0, 255));
    it.y     = 8'($urandom_range(0, 255));
    it.pg    = 4'($urandom_range(0, 15));
    it.pl    = 4'($urandom_range(0, 15));
    it.width = 8'($urandom_range(0, 255));
    it.val   = 8'($urandom_range(0, 255));
    it.on    = 1'($urandom_range(0, 1));
    it.rdy   = 1'($urandom_range(0, 1));
    it.lbusy = 1'($urandom_range(0, 1));
    it.acc   = 1'($urandom_range(0, 1));
    return it;
  endfunction

  function automatic cmd_item_t process_item(input bit rdy, input bit lbusy, input bit acc);
    cmd_item_t it;
    it       = rand_item();
    it.op    = OP_PROCESS;
    it.rdy   = rdy;
    it.lbusy = lbusy;
    it.acc   = acc;
    return it;
  endfunction

  function automatic cmd_item_t edit_item(input logic [2:0] op, input logic [7:0] x,
                                          input logic [7:0] y, input logic [3:0] pg,
                                          input logic [7:0] width, input logic [7:0] val);
    cmd_item_t it;
    it       = rand_item();
    it.op    = op;
    it.x     = x;
    it.y     = y;
    it.pg    = pg;
    it.width = width;
    it.val   = val;
    return it;
  endfunction

  function automatic cmd_item_t mark_item(input logic [3:0] pg, input logic [3:0] pl);
    cmd_item_t it;
    it    = rand_item();
    it.op = OP_MARK;
    it.pg = pg;
    it.pl = pl;
    return it;
  endfunction

  // mostly in-range edits with small fills
  function automatic cmd_item_t random_edit();
    cmd_item_t it;
    it       = rand_item();
    it.op    = ($urandom_range(0, 2) == 0) ? OP_PIXEL :
               ($urandom_range(0, 1) == 0) ? OP_FILL : OP_COLUMN;
    if ($urandom_range(0, 7) != 0) begin
      it.x  = 8'($urandom_range(0, COLUMNS - 1));
      it.y  = 8'($urandom_range(0, PAGES * 8 - 1));
      it.pg = 4'($urandom_range(0, PAGES - 1));
    end
    if ($urandom_range(0, 5) != 0) it.width = 8'($urandom_range(0, 16));
    return it;
  endfunction

  task automatic send_item(input cmd_item_t it);
    start           <= 1'b1;
    in_opcode       <= it.op;
    in_column_x     <= it.x;
    in_row_y        <= it.y;
    in_page_index   <= it.pg;
    in_page_last    <= it.pl;
    in_fill_width   <= it.width;
    in_byte_value   <= it.val;
    in_pixel_on     <= it.on;
    in_link_ready   <= it.rdy;
    in_link_busy    <= it.lbusy;
    in_link_accepts <= it.acc;
    @(posedge clk);
    while (busy) @(posedge clk);
    refresh_step(it);
    items_sent++;
    if (gaps_on && $urandom_range(0, 2) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
  endtask

  // edits, an optional mark, then a few process steps on a mostly healthy link
  task automatic refresh_round();
    int unsigned first;
    repeat ($urandom_range(1, 4)) send_item(random_edit());
    if ($urandom_range(0, 3) != 0) begin
      first = $urandom_range(0, PAGES - 1);
      send_item(mark_item(4'(first), 4'($urandom_range(first, PAGES - 1))));
    end
    repeat ($urandom_range(2, 4))
      send_item(process_item($urandom_range(0, 19) != 0, $urandom_range(0, 9) == 0,
                             $urandom_range(0, 6) != 0));
  endtask

  task automatic test_link_sequencer();
    send_item(process_item(1'b0, 1'b1, 1'b1));   // link not ready
    send_item(process_item(1'b1, 1'b1, 1'b1));   // link busy
    send_item(process_item(1'b1, 1'b0, 1'b0));   // refused command
    send_item(process_item(1'b1, 1'b0, 1'b1));   // command for page 0
    send_item(process_item(1'b1, 1'b0, 1'b0));   // data refused, stay
    send_item(process_item(1'b1, 1'b1, 1'b0));
  endtask

  task automatic test_edits();
    send_item(edit_item(OP_PIXEL, 8'd0, 8'd0, 4'd0, 8'd0, 8'd0));
    send_item(edit_item(OP_PIXEL, 8'd127, 8'd63, 4'd0, 8'd0, 8'd0));
    send_item(edit_item(OP_PIXEL, 8'd128, 8'd0, 4'd0, 8'd0, 8'd0));
    send_item(edit_item(OP_PIXEL, 8'd255, 8'd255, 4'd15, 8'd255, 8'd255));
    send_item(edit_item(OP_PIXEL, 8'd5, 8'd64, 4'd0, 8'd0, 8'd0));
    send_item(edit_item(OP_FILL, 8'd120, 8'd0, 4'd0, 8'd255, 8'hA5));
    send_item(edit_item(OP_FILL, 8'd3, 8'd0, 4'd0, 8'd0, 8'hFF));
    send_item(edit_item(OP_FILL, 8'd0, 8'd0, 4'd8, 8'd4, 8'h3C));
    send_item(edit_item(OP_FILL, 8'd255, 8'd0, 4'd15, 8'd4, 8'h3C));
    send_item(edit_item(OP_COLUMN, 8'd127, 8'd0, 4'd0, 8'd0, 8'hFF));
    send_item(edit_item(OP_COLUMN, 8'd200, 8'd0, 4'd0, 8'd0, 8'h81));
    send_item(edit_item(OP_COLUMN, 8'd1, 8'd0, 4'd9, 8'd0, 8'h81));
    send_item(process_item(1'b1, 1'b0, 1'b1));   // page 0 data
    send_item(process_item(1'b1, 1'b0, 1'b1));   // back through idle, page 1
    send_item(process_item(1'b0, 1'b0, 1'b1));
  endtask

  task automatic test_marks_and_clear();
    send_item(mark_item(4'd5, 4'd2));
    send_item(mark_item(4'd0, 4'd8));
    send_item(mark_item(4'd15, 4'd15));
    send_item(mark_item(4'd0, 4'd7));
    send_item(edit_item(OP_CLEAR, 8'd0, 8'd0, 4'd0, 8'd0, 8'd0));
    send_item(edit_item(OP_SPARE_6, 8'd0, 8'd0, 4'd0, 8'd1, 8'h55));
    send_item(edit_item(OP_SPARE_7, 8'd0, 8'd0, 4'd0, 8'd1, 8'h55));
    send_item(process_item(1'b1, 1'b0, 1'b1));
    send_item(process_item(1'b1, 1'b0, 1'b1));
  endtask

  task automatic test_random_traffic();
    cmd_item_t it;
    while (items_sent < RANDOM_ITEMS) begin
      if ($urandom_range(0, 9) < 7) begin
        refresh_round();
      end else begin
        it = rand_item();
        // clear-all costs a full sweep, keep it rare
        if (it.op == OP_CLEAR && $urandom_range(0, 2) != 0) it.op = OP_MARK;
        send_item(it);
      end
    end
  endtask

  task automatic test_back_to_back();
    int unsigned stop_at;
    gaps_on = 1'b0;
    stop_at = items_sent + BURST_ITEMS;
    while (items_sent < stop_at) refresh_round();
  endtask

  always @(posedge clk) begin
    transfer_t exp;
    if (rst_n && out_valid) begin
      if (transfer_q.size() == 0) begin
        $error("unexpected transfer: kind %0d payload %h", out_transfer_kind, out_payload);
        mismatches++;
      end else begin
        exp = transfer_q.pop_front();
        if (out_transfer_kind !== exp.kind) begin
          $error("transfer_kind: expected %0d, got %0d", exp.kind, out_transfer_kind);
          mismatches++;
        end
        if (out_payload !== exp.payload) begin
          $error("payload: expected %h, got %h", exp.payload, out_payload);
          mismatches++;
        end
        if (out_last_word !== exp.last) begin
          $error("last_word: expected %0d, got %0d", exp.last, out_last_word);
          mismatches++;
        end
      end
    end
  end

  initial begin
    cycles          = 0;
    mismatches      = 0;
    items_sent      = 0;
    gaps_on         = 1'b1;
    foreach (frame_mirror[i]) frame_mirror[i] = '0;
    dirty_pages     = '1;
    refresh_page    = '0;
    link_phase      = PH_IDLE;
    rst_n           <= 1'b0;
    start           <= 1'b0;
    in_opcode       <= OP_PROCESS;
    in_column_x     <= '0;
    in_row_y        <= '0;
    in_page_index   <= '0;
    in_page_last    <= '0;
    in_fill_width   <= '0;
    in_byte_value   <= '0;
    in_pixel_on     <= 1'b0;
    in_link_ready   <= 1'b0;
    in_link_busy    <= 1'b0;
    in_link_accepts <= 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    test_link_sequencer();
    test_edits();
    test_marks_and_clear();
    test_random_traffic();
    test_back_to_back();

    start <= 1'b0;
    while (transfer_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (transfer_q.size() != 0) begin
      $error("%0d expected transfers never seen", transfer_q.size());
      mismatches++;
    end
    if (mismatches == 0) begin
      $display("page_framebuffer_refresh_controller_unit_tb: done, clean");
    end else begin
      $display("page_framebuffer_refresh_controller_unit_tb: done, errors");
    end
    $finish;
  end

endmodule

// ----- page_framebuffer_refresh_controller_unit.f -----
+incdir+design
design/pfrc_pkg.sv
design/page_framebuffer_refresh_controller_unit.sv
design/pfrc_checker.sv
sim/page_framebuffer_refresh_controller_unit_tb.sv
